// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/frsa_pkg.sv
// types and codes for the frame ring staging allocator
// no dependencies
`default_nettype none
package frsa_pkg;
    localparam logic [2:0] K_BEGIN   = 3'd0;
    localparam logic [2:0] K_RESERVE = 3'd1;
    localparam logic [2:0] K_ENQUEUE = 3'd2;
    localparam logic [2:0] K_SUBMIT  = 3'd3;
    localparam logic [2:0] K_RES_ENQ = 3'd4;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_NOT_OPEN  = 4'd1;
    localparam logic [3:0] ST_OPEN      = 4'd2;
    localparam logic [3:0] ST_ZERO      = 4'd3;
    localparam logic [3:0] ST_EXHAUSTED = 4'd4;
    localparam logic [3:0] ST_RANGE     = 4'd5;
    localparam logic [3:0] ST_ALIGN     = 4'd6;
    localparam logic [3:0] ST_CONFIG    = 4'd7;
    localparam logic [3:0] ST_FULL      = 4'd8;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_FRAMES   = 2'd1;
    localparam logic [1:0] CFG_ALIGN    = 2'd2;

    typedef logic [39:0] t_off40;
endpackage
`default_nettype wire

// File: rtl/core/frame_ring_staging_allocator.sv
// frame ring staging allocator: per-frame bump allocator with copy list
// depends on frsa_pkg and assert_macros.svh
//
//  channel | signals                     | beat
//  in      | i_valid / o_ready           | one command
//  out     | o_valid / i_ready           | one result, o_last on final
//  cfg     | i_cfg_we, i_cfg_idx, data   | one register write
//
// begin: two 33-step serial divides, a 16-step multiply, frame wrap by
//   repeated subtract, then a 4-step multiply
// reserve: serial 33-bit modulo, then the room check
// submit: each recorded copy is read from the list memory and then emitted
// a result waits in the output register while the input stays blocked
// reset is synchronous active low and clears control state only
`default_nettype none
`include "assert_macros.svh"
module frame_ring_staging_allocator #(
    parameter int MAX_COPIES = 32,
    parameter int MAX_FRAMES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_request_size,
    input  wire logic [15:0] i_request_alignment,
    input  wire logic [31:0] i_slice_offset,
    input  wire logic [31:0] i_slice_size,
    input  wire logic [15:0] i_dest_id,
    input  wire logic [39:0] i_dest_size,
    input  wire logic [39:0] i_dest_offset,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_status,
    output logic [31:0]      o_offset,
    output logic [31:0]      o_length,
    output logic [15:0]      o_region_dest,
    output logic [39:0]      o_region_dest_offset,
    output logic [39:0]      o_barrier_start,
    output logic [39:0]      o_barrier_length,
    output logic             o_run_end,
    output logic [3:0]       o_frame_index,
    output logic [31:0]      o_bytes_used,
    output logic [5:0]       o_pending_copies,
    output logic             o_last
);
    import frsa_pkg::*;

    localparam int CW = $clog2(MAX_COPIES + 1);
    localparam int AW = (MAX_COPIES > 1) ? $clog2(MAX_COPIES) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV    = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_BEGIN2 = 4'd3;
    localparam logic [3:0] S_RES    = 4'd4;
    localparam logic [3:0] S_ENQ    = 4'd5;
    localparam logic [3:0] S_SUBRD  = 4'd6;
    localparam logic [3:0] S_SUBEM  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;
    localparam logic [3:0] S_BEGIN1 = 4'd9;

    // configuration
    logic [31:0] r_cap;
    logic [4:0]  r_frames;
    logic [15:0] r_dalign;

    // allocator state
    logic [3:0]  r_next, r_active;
    logic        r_open;
    logic [32:0] r_cursor, r_fbegin, r_fend;
    logic [CW-1:0] r_count;

    // copy list memory
    logic [15:0] m_dest [MAX_COPIES];
    logic [31:0] m_src  [MAX_COPIES];
    logic [39:0] m_doff [MAX_COPIES];
    logic [31:0] m_len  [MAX_COPIES];

    logic [3:0]  r_state;
    logic        r_pass;     // second divide pass in begin
    logic [5:0]  r_step;
    // shared serial divider / multiplier
    logic [32:0] r_rem, r_quo, r_dvs;
    logic [31:0] r_acc;
    logic [31:0] r_fc;

    // latched command
    logic [2:0]  r_kind;
    logic [31:0] r_rsize, r_so, r_ss;
    logic [15:0] r_id;
    logic [39:0] r_dsz, r_dof;
    logic [16:0] r_align;

    // submit walk
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_n;
    logic [15:0] r_rd_dest, r_prev_dest;
    logic [31:0] r_rd_src, r_rd_len;
    logic [39:0] r_rd_doff;
    logic        r_rd_first;
    logic [40:0] r_lo, r_hi;

    // output register
    logic        r_ovalid;
    logic [3:0]  r_st;
    logic [31:0] r_off, r_len;
    logic [15:0] r_rdest;
    logic [39:0] r_rdoff, r_bs, r_bl;
    logic        r_rend, r_last;

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_status = r_st;
    assign o_offset = r_off;
    assign o_length = r_len;
    assign o_region_dest = r_rdest;
    assign o_region_dest_offset = r_rdoff;
    assign o_barrier_start = r_bs;
    assign o_barrier_length = r_bl;
    assign o_run_end = r_rend;
    assign o_frame_index = r_active;
    assign o_bytes_used = r_open ? 32'(r_cursor - r_fbegin) : 32'd0;
    assign o_pending_copies = 6'(r_count);
    assign o_last = r_last;

    wire in_acc = i_valid && o_ready;
    wire out_acc = r_ovalid && i_ready;

    // divider step
    logic [33:0] div_try;
    logic [32:0] div_sh;
    always_comb begin
        div_sh  = {r_rem[31:0], r_quo[32]};
        div_try = {1'b0, div_sh} - {1'b0, r_dvs};
    end

    // reservation arithmetic after modulo
    logic [32:0] res_o;
    logic [33:0] res_room;
    logic        res_fail;
    always_comb begin
        res_o = (r_rem == 33'd0) ? r_cursor : 33'(r_cursor + ({16'd0, r_align} - r_rem));
        res_room = {1'b0, r_fend} - {1'b0, res_o};
        res_fail = (res_o > r_fend) || ({2'b0, r_rsize} > res_room);
    end

    // enqueue checks
    logic [3:0] enq_st;
    always_comb begin
        priority if (r_ss == 32'd0 || r_id == 16'd0 || {1'b0, r_so} < r_fbegin ||
                {1'b0, r_so} > r_cursor || {1'b0, r_ss} > 33'(r_cursor - {1'b0, r_so}) ||
                r_dof > r_dsz || {8'd0, r_ss} > 40'(r_dsz - r_dof)) begin
            enq_st = ST_RANGE;
        end else if (r_so[1:0] != 2'b0 || r_dof[1:0] != 2'b0) begin
            enq_st = ST_ALIGN;
        end else if (r_count >= CW'(MAX_COPIES)) begin
            enq_st = ST_FULL;
        end else begin
            enq_st = ST_OK;
        end
    end

    wire cfg_bad = (r_cap == 32'd0) || (r_frames < 5'd2) ||
                   (r_frames > 5'(MAX_FRAMES)) || (r_dalign == 16'd0);

    // submit run logic on the entry just read
    logic [40:0] sub_e, sub_lo, sub_hi;
    logic        sub_close;
    always_comb begin
        sub_e = {1'b0, r_rd_doff} + {9'd0, r_rd_len};
        if (r_rd_first || r_prev_dest != r_rd_dest) begin
            sub_lo = {1'b0, r_rd_doff};
            sub_hi = sub_e;
        end else begin
            sub_lo = ({1'b0, r_rd_doff} < r_lo) ? {1'b0, r_rd_doff} : r_lo;
            sub_hi = (sub_e > r_hi) ? sub_e : r_hi;
        end
        sub_close = (CW'(r_idx) + CW'(1) == r_n) || (m_dest[r_idx + AW'(1)] != r_rd_dest);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SUBRD || (r_state == S_SUBEM && !r_ovalid)) begin
            r_rd_dest <= m_dest[r_idx];
            r_rd_src  <= m_src[r_idx];
            r_rd_len  <= m_len[r_idx];
            r_rd_doff <= m_doff[r_idx];
        end
        if (r_state == S_ENQ && enq_st == ST_OK) begin
            m_dest[r_count[AW-1:0]] <= r_id;
            m_src[r_count[AW-1:0]]  <= r_so;
            m_doff[r_count[AW-1:0]] <= r_dof;
            m_len[r_count[AW-1:0]]  <= r_ss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 32'd0;
            r_frames <= 5'd2;
            r_dalign <= 16'd256;
            r_next <= 4'd0;
            r_active <= 4'd0;
            r_open <= 1'b0;
            r_cursor <= 33'd0;
            r_fbegin <= 33'd0;
            r_fend <= 33'd0;
            r_count <= '0;
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CAPACITY: r_cap <= i_cfg_data;
                    CFG_FRAMES:   r_frames <= i_cfg_data[4:0];
                    CFG_ALIGN:    r_dalign <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_acc) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_acc) begin
                    r_kind <= i_kind; r_rsize <= i_request_size;
                    r_so <= i_slice_offset; r_ss <= i_slice_size; r_id <= i_dest_id;
                    r_dsz <= i_dest_size; r_dof <= i_dest_offset;
                    r_st <= ST_OK; r_off <= '0; r_len <= '0; r_rdest <= '0;
                    r_rdoff <= '0; r_bs <= '0; r_bl <= '0; r_rend <= 1'b0;
                    r_last <= 1'b1;
                    r_align <= (i_request_alignment == 16'd0) ? {1'b0, r_dalign}
                                                              : {1'b0, i_request_alignment};
                    r_state <= S_BEGIN1;
                end
                S_BEGIN1: begin
                    if (r_align < 17'd4) r_align <= 17'd4;
                    priority case (r_kind)
                        K_BEGIN: begin
                            if (cfg_bad) begin
                                r_st <= ST_CONFIG; r_state <= S_OUT;
                            end else begin
                                r_rem <= '0; r_quo <= {1'b0, r_cap};
                                r_dvs <= {28'd0, r_frames}; r_step <= '0;
                                r_pass <= 1'b0; r_state <= S_DIV;
                            end
                        end
                        K_RESERVE, K_RES_ENQ: begin
                            if (!r_open) begin
                                r_st <= ST_NOT_OPEN; r_state <= S_OUT;
                            end else if (r_rsize == 32'd0) begin
                                r_st <= ST_ZERO; r_state <= S_OUT;
                            end else begin
                                r_rem <= '0; r_quo <= r_cursor;
                                r_dvs <= {16'd0, (r_align < 17'd4) ? 17'd4 : r_align};
                                r_step <= '0; r_state <= S_DIV;
                            end
                        end
                        K_ENQUEUE: begin
                            if (!r_open) begin
                                r_st <= ST_NOT_OPEN; r_state <= S_OUT;
                            end else r_state <= S_ENQ;
                        end
                        K_SUBMIT: begin
                            if (!r_open) begin
                                r_st <= ST_NOT_OPEN; r_state <= S_OUT;
                            end else begin
                                r_n <= r_count; r_idx <= '0; r_rd_first <= 1'b1;
                                r_open <= 1'b0; r_count <= '0;
                                r_next <= r_active + 4'd1;
                                r_state <= (r_count == '0) ? S_OUT : S_SUBRD;
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_DIV: begin
                    if (div_try[33]) begin
                        r_rem <= div_sh; r_quo <= {r_quo[31:0], 1'b0};
                    end else begin
                        r_rem <= div_try[32:0]; r_quo <= {r_quo[31:0], 1'b1};
                    end
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd32) begin
                        if (r_kind != K_BEGIN) begin
                            r_state <= S_RES;
                        end else if (!r_pass) begin
                            r_pass <= 1'b1; r_step <= '0; r_rem <= '0;
                            r_quo <= {r_quo[31:0], ~div_try[33]};
                            r_dvs <= {17'd0, r_dalign};
                        end else begin
                            r_acc <= '0; r_fc <= {r_quo[30:0], ~div_try[33]};
                            r_step <= '0; r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    // shift-add: fc = quotient * default alignment
                    if (r_step[4:0] == 5'd16) begin
                        if (r_acc == 32'd0) begin
                            r_st <= ST_CONFIG; r_state <= S_OUT;
                        end else if (r_open) begin
                            r_st <= ST_OPEN; r_state <= S_OUT;
                        end else begin
                            r_fc <= r_acc; r_acc <= '0; r_step <= '0;
                            r_active <= r_next;
                            r_state <= S_BEGIN2;
                        end
                    end else begin
                        r_acc <= (r_acc << 1) + (r_dalign[15 - r_step[3:0]] ? r_fc : 32'd0);
                        r_step <= r_step + 6'd1;
                    end
                end
                S_BEGIN2: begin
                    // wrap next frame into range, then frame_begin = active * fc
                    if (r_step == 6'd0 && {1'b0, r_active} >= r_frames) begin
                        r_active <= r_active - 4'(r_frames);
                    end else if (r_step == 6'd4) begin
                        r_fbegin <= {1'b0, r_acc}; r_cursor <= {1'b0, r_acc};
                        r_fend <= {1'b0, r_acc} + {1'b0, r_fc};
                        r_count <= '0; r_open <= 1'b1;
                        r_off <= r_acc; r_len <= r_fc; r_state <= S_OUT;
                    end else begin
                        r_acc <= (r_acc << 1) + (r_active[3 - r_step[1:0]] ? r_fc : 32'd0);
                        r_step <= r_step + 6'd1;
                    end
                end
                S_RES: begin
                    if (res_fail) begin
                        r_st <= ST_EXHAUSTED; r_state <= S_OUT;
                    end else begin
                        r_cursor <= res_o + {1'b0, r_rsize};
                        r_off <= res_o[31:0]; r_len <= r_rsize;
                        if (r_kind == K_RES_ENQ) begin
                            r_so <= res_o[31:0]; r_ss <= r_rsize;
                            r_state <= S_ENQ;
                        end else r_state <= S_OUT;
                    end
                end
                S_ENQ: begin
                    r_st <= enq_st;
                    if (enq_st == ST_OK) r_count <= r_count + CW'(1);
                    r_state <= S_OUT;
                end
                S_SUBRD: r_state <= S_SUBEM;
                S_SUBEM: if (!r_ovalid) begin
                    r_ovalid <= 1'b1; r_last <= 1'b0; r_st <= ST_OK;
                    r_off <= r_rd_src; r_len <= r_rd_len; r_rdest <= r_rd_dest;
                    r_rdoff <= r_rd_doff; r_rend <= sub_close;
                    r_bs <= sub_close ? sub_lo[39:0] : 40'd0;
                    r_bl <= sub_close ? 40'(sub_hi - sub_lo) : 40'd0;
                    r_lo <= sub_lo; r_hi <= sub_hi;
                    r_prev_dest <= r_rd_dest; r_rd_first <= 1'b0;
                    if (CW'(r_idx) + CW'(1) == r_n) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx + AW'(1); r_state <= S_SUBRD;
                    end
                end
                S_OUT: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    if (r_kind == K_SUBMIT && r_st == ST_OK) begin
                        r_last <= 1'b1; r_off <= '0; r_len <= '0; r_rdest <= '0;
                        r_rdoff <= '0; r_bs <= '0; r_bl <= '0; r_rend <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_COPIES))
    `ASSERT_NEXT(a_closed_after_last, i_clk, i_rst_n,
                 out_acc && r_last && r_kind == K_SUBMIT && r_st == ST_OK, !r_open)
endmodule
`default_nettype wire
